/* hdl/bse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg: shared definitions for the bubble sort engine
// Buffer geometry, word widths and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic pass_start;
        logic pass_first;
        logic pass_step;
        logic pass_end;
        logic out_load;
    } bse_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic single;
        logic pass_done;
        logic sort_done;
        logic out_free;
        logic out_last;
    } bse_sts_t;

endpackage

`default_nettype wire

/* hdl/bse_load_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_load_if: input channel of the bubble sort engine
// Carries one element word and its end-of-set mark under valid/ready.
// ----------------------------------------------------------------------------
interface bse_load_if
    import bse_pkg::*;
    ();

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value;
    logic                     last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

`default_nettype wire

/* hdl/bse_drain_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_drain_if: output channel of the bubble sort engine
// Carries one sorted word with its end and overflow marks under valid/ready.
// ----------------------------------------------------------------------------
interface bse_drain_if
    import bse_pkg::*;
    ();

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value_res;
    logic                     last_res;
    logic                     overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                     input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                     output ready);

endinterface

`default_nettype wire

/* hdl/bse_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_datapath: element buffer, compare-swap unit and output register
// Holds the set in a single-port-write, registered-read buffer. A pass walks
// the buffer with one carried word, writing back the smaller of each pair.
// ----------------------------------------------------------------------------
module bse_datapath
    import bse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bse_cmd_t cmd,
    output bse_sts_t      sts,
    bse_load_if.sink      load,
    bse_drain_if.source   drain
);

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              dropped_reg, dropped_next;
    logic [ADDR_W-1:0] idx_reg,     idx_next;
    logic [ADDR_W-1:0] end_reg,     end_next;
    logic              swapped_reg, swapped_next;
    logic              out_valid_reg, out_valid_next;

    logic [WORD_W-1:0] hold_reg,    hold_next;
    logic [WORD_W-1:0] res_reg,     res_next;
    logic              res_last_reg, res_last_next;
    logic              res_ovf_reg,  res_ovf_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              full;
    logic              swap;
    logic [ADDR_W-1:0] last_idx;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign swap     = $signed(hold_reg) > $signed(rdata_reg);
    assign last_idx = ADDR_W'(count_reg - CNT_W'(1));

    assign sts.in_fire   = load.valid & cmd.load;
    assign sts.in_last   = load.last;
    assign sts.single    = (count_reg == CNT_W'(1));
    assign sts.pass_done = (idx_reg == end_reg);
    assign sts.sort_done = !swapped_reg || (end_reg == ADDR_W'(1));
    assign sts.out_free  = !out_valid_reg || drain.ready;
    assign sts.out_last  = (idx_reg == last_idx);

    assign load.ready      = cmd.load;
    assign drain.valid     = out_valid_reg;
    assign drain.value_res = res_reg;
    assign drain.last_res  = res_last_reg;
    assign drain.overflow  = res_ovf_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = load.value;
        rd_addr = idx_reg;
        if (sts.in_fire)
        begin
            wr_en = !full;
        end
        else if (cmd.pass_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.pass_first)
        begin
            rd_addr = ADDR_W'(1);
        end
        else if (cmd.pass_step)
        begin
            rd_addr = idx_reg + ADDR_W'(1);
            wr_en   = 1'b1;
            wr_addr = idx_reg - ADDR_W'(1);
            wr_data = swap ? rdata_reg : hold_reg;
        end
        else if (cmd.pass_end)
        begin
            wr_en   = 1'b1;
            wr_addr = end_reg;
            wr_data = hold_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        swapped_next   = swapped_reg;
        hold_next      = hold_reg;
        res_next       = res_reg;
        res_last_next  = res_last_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;

        if (drain.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (sts.in_fire)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.sort_init)
        begin
            end_next = last_idx;
            idx_next = '0;
        end
        else if (cmd.pass_start)
        begin
            swapped_next = 1'b0;
        end
        else if (cmd.pass_first)
        begin
            hold_next = rdata_reg;
            idx_next  = ADDR_W'(1);
        end
        else if (cmd.pass_step)
        begin
            hold_next    = swap ? hold_reg : rdata_reg;
            swapped_next = swapped_reg | swap;
            idx_next     = idx_reg + ADDR_W'(1);
        end
        else if (cmd.pass_end)
        begin
            end_next = end_reg - ADDR_W'(1);
            idx_next = '0;
        end
        else if (cmd.out_load)
        begin
            res_next       = rdata_reg;
            res_last_next  = sts.out_last;
            res_ovf_next   = dropped_reg;
            out_valid_next = 1'b1;
            if (sts.out_last)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rdata_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            idx_reg       <= '0;
            end_reg       <= '0;
            swapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            swapped_reg   <= swapped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        res_reg      <= res_next;
        res_last_reg <= res_last_next;
        res_ovf_reg  <= res_ovf_next;
    end

endmodule

`default_nettype wire

/* hdl/bse_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_controller: sequencer of the bubble sort engine
// Steps through loading, compare-swap passes with early exit and the
// read-out of the sorted set.
// ----------------------------------------------------------------------------
module bse_controller
    import bse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bse_sts_t sts,
    output bse_cmd_t      cmd
);

    typedef enum logic [7:0] {
        ST_LOAD       = 8'b0000_0001,
        ST_SORT_INIT  = 8'b0000_0010,
        ST_PASS_START = 8'b0000_0100,
        ST_PASS_FIRST = 8'b0000_1000,
        ST_PASS_STEP  = 8'b0001_0000,
        ST_PASS_END   = 8'b0010_0000,
        ST_OUT_READ   = 8'b0100_0000,
        ST_OUT_LOAD   = 8'b1000_0000
    } bse_state_t;

    bse_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (sts.in_fire && sts.in_last)
                begin
                    state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = sts.single ? ST_OUT_READ : ST_PASS_START;
            end
            ST_PASS_START:
            begin
                cmd.pass_start = 1'b1;
                state_next     = ST_PASS_FIRST;
            end
            ST_PASS_FIRST:
            begin
                cmd.pass_first = 1'b1;
                state_next     = ST_PASS_STEP;
            end
            ST_PASS_STEP:
            begin
                cmd.pass_step = 1'b1;
                if (sts.pass_done)
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END:
            begin
                cmd.pass_end = 1'b1;
                state_next   = sts.sort_done ? ST_OUT_READ : ST_PASS_START;
            end
            ST_OUT_READ:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_OUT_LOAD;
                end
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = sts.out_last ? ST_LOAD : ST_OUT_READ;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bubble_sort_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_engine: load, sort ascending and stream out a set of words
// Input channel load: one signed 32-bit word per handshake, one per cycle
// while loading; the word marked last closes the set. Up to 64 words are
// kept, later ones are dropped and every output word of that set then
// carries overflow. Sorting: compare-swap passes over the buffer, one
// carried word and one buffer read and write per cycle; the first pass
// covers the whole set and each later one is one shorter. Sorting stops
// after a pass with no swap or after the final pass.
// Output channel drain: sorted words in order, last_res on the final one;
// a stalled receiver holds the output register and the buffer read-out
// waits behind it. Load reopens as soon as the final word sits in the
// output register.
// Reset clears the set count, the overflow mark and the sequencer; buffer
// contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module bubble_sort_engine
    import bse_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bse_load_if.sink    load,
    bse_drain_if.source drain
);

    bse_cmd_t cmd;
    bse_sts_t sts;

    bse_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bse_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .load  (load),
        .drain (drain)
    );

endmodule

`default_nettype wire
